// ===== src/sle_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine package
// Shared word types, operation and status codes, and the command and status
// groups that pass between the controller and the datapath.
// ----------------------------------------------------------------------------
package sle_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int VALUE_W      = 32;
    localparam int OP_W         = 3;
    localparam int ST_W         = 3;
    localparam int OCC_W        = 5;

    // Operation codes of an input word.
    localparam logic [OP_W-1:0] OP_INSERT    = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE    = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH    = 3'd2;
    localparam logic [OP_W-1:0] OP_DUMP_ASC  = 3'd3;
    localparam logic [OP_W-1:0] OP_DUMP_DESC = 3'd4;
    localparam logic [OP_W-1:0] OP_CLEAR     = 3'd5;

    // Status codes of a result word.
    localparam logic [ST_W-1:0] ST_INSERTED  = 3'd0;
    localparam logic [ST_W-1:0] ST_REMOVED   = 3'd1;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 3'd2;
    localparam logic [ST_W-1:0] ST_FOUND     = 3'd3;
    localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
    localparam logic [ST_W-1:0] ST_ELEMENT   = 3'd5;
    localparam logic [ST_W-1:0] ST_EMPTY     = 3'd6;
    localparam logic [ST_W-1:0] ST_CLEARED   = 3'd7;

    // Source of the element field of a result word.
    localparam logic [1:0] ESEL_OPERAND = 2'd0;
    localparam logic [1:0] ESEL_ZERO    = 2'd1;
    localparam logic [1:0] ESEL_HEAD    = 2'd2;
    localparam logic [1:0] ESEL_TAIL    = 2'd3;

    typedef struct packed {
        logic [OP_W-1:0]           operation;
        logic signed [VALUE_W-1:0] value;
    } t_in_word;

    typedef struct packed {
        logic [ST_W-1:0]           status;
        logic signed [VALUE_W-1:0] element;
        logic [OCC_W-1:0]          occupancy;
        logic                      last;
    } t_out_word;

    typedef struct packed {
        logic            latch;
        logic            cmp;
        logic            ins;
        logic            rem;
        logic            clr;
        logic            emit;
        logic            rot_asc;
        logic            rot_desc;
        logic            last;
        logic [ST_W-1:0] status;
        logic [1:0]      esel;
    } t_sle_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            full;
        logic            found;
        logic            empty;
        logic            dump_last;
    } t_sle_stat;

endpackage

// ===== src/sorted_list_engine_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine
// Keeps signed 32-bit values in ascending order with insert, remove, search,
// dump and clear operations.
// ----------------------------------------------------------------------------
// Usage:
// An input word carries an operation and a value and is taken at a rising
// edge where i_in_valid is high and o_in_stall is low. Result words leave on
// o_out_data under o_out_valid and are taken when i_out_stall is low; each
// result word holds until taken. The last result of an operation has last
// set. Codes 6 and 7 of the operation field produce no result.
// Insert, remove, search and clear give one result each: the compare
// state registers the per-cell compares, then the apply state shifts the
// cell chain and loads the result register. The next word is taken in the
// apply state, so a new word is taken only once the compares of the last
// one are registered. A dump of an empty store gives one empty word, else one
// result per stored value, one a cycle while the output is not stalled, by
// rotating the cell chain through its head or tail; the next word can be
// taken in the cycle after its last result is loaded.
// A stall on the output holds the sequencer in its emit state with the
// result register full, and the input stays stalled meanwhile; only while
// idle can one word still be taken and compared. Reset empties the store at
// once; it needs no clearing pass.
// ----------------------------------------------------------------------------
module sorted_list_engine_top import sle_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  t_in_word  i_in_data,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_word o_out_data
);

    t_sle_cmd  w_cmd;
    t_sle_stat w_stat;

    // The controller decides what happens each cycle from the datapath's
    // compare and count flags and from the output handshake.
    sle_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // The datapath holds the values, one register cell each, and the result
    // register that drives the output word.
    sle_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (w_cmd),
        .o_stat     (w_stat),
        .o_out_data (o_out_data)
    );

endmodule

// ===== src/sle_datapath.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine datapath
// A chain of value cells with a comparator per cell, the entry count, the
// operand register and the result register.
// ----------------------------------------------------------------------------
module sle_datapath import sle_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_word  i_in_data,
    input  t_sle_cmd  i_cmd,
    output t_sle_stat o_stat,
    output t_out_word o_out_data
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    logic signed [VALUE_W-1:0] r_cell [CAPACITY];
    logic [CAPACITY-1:0]       r_lt;
    logic [CAPACITY-1:0]       r_eq;
    logic [CW-1:0]             r_count;
    logic [CW-1:0]             n_count;
    logic [IW-1:0]             r_idx;
    logic [OP_W-1:0]           r_op;
    logic signed [VALUE_W-1:0] r_value;
    t_out_word                 r_out;
    logic [CW-1:0]             w_tail_full;
    logic [IW-1:0]             w_tail;
    logic signed [VALUE_W-1:0] w_elem;

    assign w_tail_full = r_count - 1'b1;
    assign w_tail      = w_tail_full[IW-1:0];

    // One cell per storage slot. Each cell looks at its neighbors, the
    // operand and the registered compare bits; head and tail see each other.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic                      w_valid;
        logic                      w_ins_here;
        logic signed [VALUE_W-1:0] w_left;
        logic signed [VALUE_W-1:0] w_right;
        logic signed [VALUE_W-1:0] n_cell;

        assign w_valid = CW'(g) < r_count;

        if (g == 0) begin : g_head
            assign w_ins_here = 1'b1;
            assign w_left     = r_cell[w_tail];
        end else begin : g_body
            assign w_ins_here = r_lt[g-1];
            assign w_left     = r_cell[g-1];
        end

        if (g == CAPACITY - 1) begin : g_end
            assign w_right = r_cell[g];
        end else begin : g_mid
            assign w_right = r_cell[g+1];
        end

        always_comb begin
            n_cell = r_cell[g];
            if (i_cmd.ins && !r_lt[g]) begin
                n_cell = w_ins_here ? r_value : w_left;
            end else if (i_cmd.rem && !r_lt[g]) begin
                n_cell = w_right;
            end else if (i_cmd.rot_asc) begin
                n_cell = (CW'(g + 1) == r_count) ? r_cell[0] : w_right;
            end else if (i_cmd.rot_desc) begin
                n_cell = w_left;
            end
        end

        always_ff @(posedge i_clk) begin
            r_cell[g] <= n_cell;
            if (i_cmd.cmp) begin
                r_lt[g] <= w_valid && (r_cell[g] < r_value);
                r_eq[g] <= w_valid && (r_cell[g] == r_value);
            end
        end
    end

    always_comb begin
        n_count = r_count;
        if (i_cmd.clr) begin
            n_count = '0;
        end else if (i_cmd.ins) begin
            n_count = r_count + 1'b1;
        end else if (i_cmd.rem) begin
            n_count = r_count - 1'b1;
        end
    end

    always_comb begin
        unique case (i_cmd.esel)
            ESEL_OPERAND: w_elem = r_value;
            ESEL_ZERO:    w_elem = '0;
            ESEL_HEAD:    w_elem = r_cell[0];
            ESEL_TAIL:    w_elem = r_cell[w_tail];
            default:      w_elem = r_value;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
        if (i_cmd.latch) begin
            r_op    <= i_in_data.operation;
            r_value <= i_in_data.value;
        end
        if (i_cmd.cmp) begin
            r_idx <= '0;
        end else if (i_cmd.rot_asc || i_cmd.rot_desc) begin
            r_idx <= r_idx + 1'b1;
        end
        if (i_cmd.emit) begin
            r_out.status    <= i_cmd.status;
            r_out.element   <= w_elem;
            r_out.occupancy <= OCC_W'(n_count);
            r_out.last      <= i_cmd.last;
        end
    end

    assign o_stat.op        = r_op;
    assign o_stat.full      = r_count >= CW'(CAPACITY);
    assign o_stat.found     = |r_eq;
    assign o_stat.empty     = r_count == '0;
    assign o_stat.dump_last = CW'(r_idx) == w_tail_full;
    assign o_out_data       = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(CAPACITY))
        else $error("entry count beyond capacity");

    a_ins_not_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.ins |-> r_count < CW'(CAPACITY))
        else $error("insert applied to a full store");

    a_rem_found: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rem |-> (|r_eq))
        else $error("remove applied without a matching value");

endmodule

// ===== src/sle_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine controller
// Sequences capture, compare, update and result emission, and owns the
// handshake of both channels.
// ----------------------------------------------------------------------------
module sle_ctrl import sle_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_stall,
    input  logic      i_out_stall,
    output logic      o_out_valid,
    input  t_sle_stat i_stat,
    output t_sle_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_DUMP  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       w_out_free;

    assign w_out_free = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_stall = 1'b1;
        unique case (r_state)
            S_IDLE: begin
                o_in_stall = 1'b0;
                if (i_in_valid) begin
                    o_cmd.latch = 1'b1;
                    n_state     = S_CMP;
                end
            end
            S_CMP: begin
                o_cmd.cmp = 1'b1;
                case (i_stat.op) inside
                    OP_INSERT, OP_REMOVE, OP_SEARCH, OP_CLEAR: n_state = S_APPLY;
                    OP_DUMP_ASC, OP_DUMP_DESC:                 n_state = S_DUMP;
                    default:                                   n_state = S_IDLE;
                endcase
            end
            S_APPLY: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    o_cmd.last = 1'b1;
                    o_cmd.esel = ESEL_OPERAND;
                    case (i_stat.op)
                        OP_INSERT: begin
                            o_cmd.ins    = !i_stat.full;
                            o_cmd.status = i_stat.full ? ST_FULL : ST_INSERTED;
                        end
                        OP_REMOVE: begin
                            o_cmd.rem    = i_stat.found;
                            o_cmd.status = i_stat.found ? ST_REMOVED : ST_NOT_FOUND;
                        end
                        OP_SEARCH: begin
                            o_cmd.status = i_stat.found ? ST_FOUND : ST_NOT_FOUND;
                        end
                        default: begin
                            o_cmd.clr    = 1'b1;
                            o_cmd.status = ST_CLEARED;
                        end
                    endcase
                    // The next word is taken in the same cycle as the update.
                    o_in_stall = 1'b0;
                    if (i_in_valid) begin
                        o_cmd.latch = 1'b1;
                        n_state     = S_CMP;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DUMP: begin
                if (w_out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_stat.empty) begin
                        o_cmd.status = ST_EMPTY;
                        o_cmd.esel   = ESEL_ZERO;
                        o_cmd.last   = 1'b1;
                        n_state      = S_IDLE;
                    end else begin
                        o_cmd.status = ST_ELEMENT;
                        o_cmd.last   = i_stat.dump_last;
                        if (i_stat.op == OP_DUMP_ASC) begin
                            o_cmd.esel    = ESEL_HEAD;
                            o_cmd.rot_asc = 1'b1;
                        end else begin
                            o_cmd.esel     = ESEL_TAIL;
                            o_cmd.rot_desc = 1'b1;
                        end
                        if (i_stat.dump_last) begin
                            n_state = S_IDLE;
                        end
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_emit_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> (!r_out_valid || !i_out_stall))
        else $error("result word overwritten while stalled");

    a_accept_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_state == S_CMP)
        else $error("accepted word not sent to compare");

    a_accept_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_stall |-> (r_state == S_IDLE || r_state == S_APPLY))
        else $error("input open while busy");

endmodule

// ===== sim/sorted_list_engine_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine checker
// Watches both channels of the engine, keeps its own copy of the sorted store
// to work out the result words of every accepted input word, and compares
// each accepted result word with the oldest one still awaited.
// ----------------------------------------------------------------------------
module sorted_list_engine_checker import sle_pkg::*; #(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_in_stall,
    input  t_in_word  i_in_data,
    input  logic      i_out_valid,
    input  logic      i_out_stall,
    input  t_out_word i_out_data,
    output int        o_fail_count,
    output int        o_pending
);

    logic signed [VALUE_W-1:0] stored_vals [CAPACITY];
    int                        stored_len;
    t_out_word                 awaited_q [$];
    int                        fail_total;

    function automatic t_out_word result_word(logic [ST_W-1:0] st,
                                              logic signed [VALUE_W-1:0] el,
                                              logic lst);
        t_out_word w;
        w.status    = st;
        w.element   = el;
        w.occupancy = OCC_W'(stored_len);
        w.last      = lst;
        return w;
    endfunction

    // Applies one input word to the shadow store and queues its result words.
    task automatic apply_list_op(input t_in_word w);
        int                        pos;
        logic signed [VALUE_W-1:0] v;
        v = w.value;
        case (w.operation)
            OP_INSERT: begin
                if (stored_len >= CAPACITY) begin
                    awaited_q.push_back(result_word(ST_FULL, v, 1'b1));
                end else begin
                    pos = 0;
                    while (pos < stored_len && stored_vals[pos] < v) pos++;
                    for (int i = stored_len; i > pos; i--) stored_vals[i] = stored_vals[i-1];
                    stored_vals[pos] = v;
                    stored_len++;
                    awaited_q.push_back(result_word(ST_INSERTED, v, 1'b1));
                end
            end
            OP_REMOVE, OP_SEARCH: begin
                pos = 0;
                while (pos < stored_len && stored_vals[pos] != v) pos++;
                if (pos == stored_len) begin
                    awaited_q.push_back(result_word(ST_NOT_FOUND, v, 1'b1));
                end else if (w.operation == OP_SEARCH) begin
                    awaited_q.push_back(result_word(ST_FOUND, v, 1'b1));
                end else begin
                    for (int i = pos; i + 1 < stored_len; i++) stored_vals[i] = stored_vals[i+1];
                    stored_len--;
                    awaited_q.push_back(result_word(ST_REMOVED, v, 1'b1));
                end
            end
            OP_DUMP_ASC, OP_DUMP_DESC: begin
                if (stored_len == 0) begin
                    awaited_q.push_back(result_word(ST_EMPTY, '0, 1'b1));
                end else begin
                    for (int k = 0; k < stored_len; k++) begin
                        pos = (w.operation == OP_DUMP_ASC) ? k : stored_len - 1 - k;
                        awaited_q.push_back(result_word(ST_ELEMENT, stored_vals[pos],
                                                        k + 1 == stored_len));
                    end
                end
            end
            OP_CLEAR: begin
                stored_len = 0;
                awaited_q.push_back(result_word(ST_CLEARED, v, 1'b1));
            end
            default: begin
                // Reserved codes are dropped by the engine without a result.
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_out_word want;
        if (!i_rst_n) begin
            stored_len = 0;
            awaited_q.delete();
            fail_total = 0;
        end else begin
            if (i_in_valid && !i_in_stall) apply_list_op(i_in_data);
            if (i_out_valid && !i_out_stall) begin
                if (awaited_q.size() == 0) begin
                    fail_total++;
                    $display("%0t: unexpected result, expected none,", $time,
                             " got st=%0d el=%0d occ=%0d last=%0d",
                             i_out_data.status, i_out_data.element,
                             i_out_data.occupancy, i_out_data.last);
                end else begin
                    want = awaited_q.pop_front();
                    if (i_out_data.status    !== want.status  ||
                        i_out_data.element   !== want.element ||
                        i_out_data.occupancy !== want.occupancy ||
                        i_out_data.last      !== want.last) begin
                        fail_total++;
                        $display("%0t: mismatch, expected st=%0d el=%0d occ=%0d last=%0d,",
                                 $time, want.status, want.element, want.occupancy,
                                 want.last, " got st=%0d el=%0d occ=%0d last=%0d",
                                 i_out_data.status, i_out_data.element,
                                 i_out_data.occupancy, i_out_data.last);
                    end
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= awaited_q.size();
    end

endmodule

// ===== sim/sorted_list_engine_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted list engine testbench
// Drives directed and random operation words into the engine with random
// gaps on the input and random stalls on the output, and leaves prediction
// and comparison to the checker that sits beside the engine.
// ----------------------------------------------------------------------------
module sorted_list_engine_top_test;
    import sle_pkg::*;

    // The two operation codes that the engine must ignore.
    localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

    localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'h8000_0000;
    localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'h7FFF_FFFF;

    localparam int RANDOM_WORDS = 420;
    localparam int PHASE_LEN    = 40;
    // Long enough for a full dump after the compare state, with margin.
    localparam int DRAIN_CYCLES = 60;
    localparam int SETTLE_LIMIT = 20000;

    logic      clk = 1'b0;
    logic      rst_n;
    logic      in_valid;
    logic      in_stall;
    t_in_word  in_data;
    logic      out_valid;
    logic      out_stall;
    t_out_word out_data;

    int        fail_count;
    int        pending;

    // Pacing controls: a calm side never idles, which gives stretches of
    // back-to-back traffic between the noisy ones.
    bit        tx_calm;
    bit        rx_calm;
    int        rx_hold;
    int        rx_gap;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    sorted_list_engine_top #(
        .CAPACITY (CAPACITY_DEF)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    sorted_list_engine_checker #(
        .CAPACITY (CAPACITY_DEF)
    ) u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // Most gaps are zero or short, and about one in ten is long.
    function automatic int pick_gap(bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(5, 30);
    endfunction

    // Operands lean toward a handful of small values and the extremes so that
    // duplicates, search hits and removals are frequent; the rest are fully
    // random so that every bit of the value field toggles.
    function automatic logic signed [VALUE_W-1:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15) begin
            case ($urandom_range(0, 5))
                0:       return VAL_MIN;
                1:       return VAL_MAX;
                2:       return VAL_MIN + 1;
                3:       return VAL_MAX - 1;
                4:       return -1;
                default: return 0;
            endcase
        end
        if (r < 65) return $signed($urandom_range(0, 16)) - 8;
        return $urandom;
    endfunction

    // Mode 0 fills the store toward full, mode 1 keeps it balanced and
    // mode 2 drains it toward empty.
    function automatic logic [OP_W-1:0] pick_op(int mode);
        int r;
        int t_ins;
        int t_rem;
        r = $urandom_range(0, 99);
        case (mode)
            0: begin
                t_ins = 62;
                t_rem = 70;
            end
            1: begin
                t_ins = 38;
                t_rem = 62;
            end
            default: begin
                t_ins = 20;
                t_rem = 62;
            end
        endcase
        if (r < t_ins) return OP_INSERT;
        if (r < t_rem) return OP_REMOVE;
        if (r < t_rem + 12) return OP_SEARCH;
        if (r < t_rem + 17) return OP_DUMP_ASC;
        if (r < t_rem + 22) return OP_DUMP_DESC;
        if (r < t_rem + 24) return OP_CLEAR;
        if (r < t_rem + 27) return ($urandom_range(0, 1) != 0) ? OP_RSVD_6 : OP_RSVD_7;
        return OP_SEARCH;
    endfunction

    // Sends one word. The optional gap comes first, so that valid is touched
    // only once in the step in which the previous word was taken. The task
    // returns at the edge that takes the word.
    task automatic issue(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] v);
        int g;
        g = pick_gap(tx_calm);
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
        in_valid          <= 1'b1;
        in_data.operation <= op;
        in_data.value     <= v;
        do @(posedge clk); while (in_stall);
    endtask

    // Output back-pressure: a stall lasts for the length of one drawn gap.
    always @(posedge clk) begin
        if (rx_hold > 0) begin
            rx_hold <= rx_hold - 1;
        end else begin
            rx_gap = pick_gap(rx_calm);
            if (rx_gap == 0) begin
                out_stall <= 1'b0;
            end else begin
                out_stall <= 1'b1;
                rx_hold   <= rx_gap - 1;
            end
        end
    end

    initial begin
        int               sent;
        int               phase_left;
        int               mode;
        int               waited;
        logic [OP_W-1:0]  op;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        out_stall <= 1'b0;
        rx_hold    = 0;
        tx_calm    = 1'b0;
        rx_calm    = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. An empty store first: both dumps give the single
        // empty word, and remove and search both miss.
        issue(OP_DUMP_ASC, $urandom);
        issue(OP_DUMP_DESC, $urandom);
        issue(OP_REMOVE, 5);
        issue(OP_SEARCH, 5);
        // Reserved codes must leave no trace at all.
        issue(OP_RSVD_6, $urandom);
        issue(OP_RSVD_7, $urandom);
        // Fill the store with the extremes, a duplicate and small values.
        issue(OP_INSERT, VAL_MIN);
        issue(OP_INSERT, VAL_MAX);
        issue(OP_INSERT, 0);
        issue(OP_INSERT, -1);
        issue(OP_INSERT, 0);
        for (int k = 0; k < CAPACITY_DEF - 5; k++) issue(OP_INSERT, pick_value());
        // The store is now full, so this insert is refused.
        issue(OP_INSERT, 42);
        issue(OP_SEARCH, 0);
        issue(OP_REMOVE, 0);
        issue(OP_DUMP_ASC, $urandom);
        issue(OP_DUMP_DESC, $urandom);
        issue(OP_CLEAR, $urandom);

        // Random part in phases, each with its own operation mix and pacing.
        sent       = 0;
        phase_left = 0;
        mode       = 0;
        while (sent < RANDOM_WORDS) begin
            if (phase_left == 0) begin
                phase_left = PHASE_LEN;
                mode       = $urandom_range(0, 2);
                tx_calm    = ($urandom_range(0, 3) == 0);
                rx_calm    = ($urandom_range(0, 3) == 0);
            end
            op = pick_op(mode);
            issue(op, pick_value());
            if (op != OP_RSVD_6 && op != OP_RSVD_7) begin
                sent++;
                phase_left--;
            end
        end
        in_valid <= 1'b0;
        rx_calm   = 1'b1;

        // Let every awaited word arrive, then watch a while longer for
        // anything extra.
        waited = 0;
        while (pending != 0 && waited < SETTLE_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending != 0)
            $display("%0t: %0d result words never arrived", $time, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest legal run, with every dump at full
    // size and every gap and stall at its longest.
    initial begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
